FILE: rtl/mfa_pkg.sv
// Shared types and constants for the mixed fraction ALU.
// Holds the field widths, the operation codes, the datapath command and status
// structs and the state encodings used by the controller and the GCD unit.
package mfa_pkg;

   // Default internal arithmetic width and the fixed widths of the stream fields.
   localparam int DATA_WIDTH_DEF = 16;
   localparam int EXT_WIDTH      = 32;
   localparam int FIELD_WIDTH    = 16;
   localparam int CMD_WIDTH      = 2;
   localparam int REQ_DATA_WIDTH = 6 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = 3 * FIELD_WIDTH;

   // Operation selector carried with each request.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } alu_cmd_type;

   // Micro-operations the controller issues to the datapath, one per cycle.
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_GCD_DEN,
      OP_GCD_RES,
      OP_DIV_BG,
      OP_DIV_LA,
      OP_DIV_LB,
      OP_DIV_NR,
      OP_DIV_NG,
      OP_DIV_DG,
      OP_WB_T,
      OP_WB_QR_ADD,
      OP_WB_QR_SET,
      OP_WB_RN,
      OP_WB_RD,
      OP_LCM,
      OP_MUL_TA,
      OP_MUL_TB,
      OP_COMBINE,
      OP_MUL_AW,
      OP_ADD_A,
      OP_MUL_BW,
      OP_ADD_B,
      OP_MUL_RN,
      OP_MUL_RD,
      OP_ERR,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic den_zero;
      logic is_muldiv;
      logic rd_zero;
      logic rn_ge_rd;
      logic div_done;
      logic gcd_done;
   } dp_status_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_W_GCD_L,
      ST_W_BG,
      ST_LCM,
      ST_START_LA,
      ST_W_LA,
      ST_MUL_TA,
      ST_START_LB,
      ST_W_LB,
      ST_MUL_TB,
      ST_COMBINE,
      ST_CARRY,
      ST_W_CARRY,
      ST_ADD_A,
      ST_MUL_BW,
      ST_ADD_B,
      ST_MUL_RN,
      ST_MUL_RD,
      ST_TEST_RD,
      ST_W_QR,
      ST_GCD_R,
      ST_W_GCD_R,
      ST_W_NG,
      ST_START_DG,
      ST_W_DG,
      ST_ERR,
      ST_EMIT
   } ctrl_state_type;

   // Phases of the binary GCD unit.
   typedef enum logic [1:0] {
      GCD_IDLE,
      GCD_TWOS,
      GCD_ODD
   } gcd_phase_type;

endpackage

FILE: rtl/mixed_fraction_alu_unit.sv
// Mixed fraction ALU: add, subtract, multiply or divide two mixed numbers
// (whole, numerator, denominator) and return one mixed number with a status
// flag. One request is worked at a time; a zero denominator skips the divider
// and GCD units. The time is set by the shared divider, which produces one
// quotient bit per cycle and runs up to four times per request, and by the
// binary GCD unit, one shift or subtract per cycle. A new request is taken as
// soon as the previous one has moved into the result register, even while that
// result still waits for rsp_tready. Arithmetic wraps to DATA_WIDTH bits;
// fields on the ports are 16 bits.
// Depends on mfa_pkg, mfa_ctrl and mfa_datapath.
module mixed_fraction_alu_unit #(
   parameter int DATA_WIDTH = mfa_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // a_whole, a_num, a_den, b_whole, b_num, b_den, 16 bits each from bit 0 up.
   input  logic [mfa_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // cmd: 0 add, 1 subtract, 2 multiply, 3 divide.
   input  logic [mfa_pkg::CMD_WIDTH-1:0]      req_tuser,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // r_whole, r_num, r_den, 16 bits each from bit 0 up.
   output logic [mfa_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // status: 1 for a zero input denominator or a zero result denominator.
   output logic                               rsp_tuser
);

   mfa_pkg::dp_ctrl_type   ctrl;
   mfa_pkg::dp_status_type status;

   mfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   mfa_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

FILE: rtl/mfa_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by the mixed fraction ALU datapath.
module mfa_divider #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder,
   output logic                  done
);

   localparam int CW = $clog2(DATA_WIDTH + 1);
   localparam logic [CW-1:0] STEPS = CW'(DATA_WIDTH);
   localparam logic [CW-1:0] LAST  = CW'(1);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH+1:0] diff;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
         count_in = STEPS;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (diff[DATA_WIDTH+1]) begin
            rem_in = shifted[DATA_WIDTH-1:0];
         end else begin
            rem_in = diff[DATA_WIDTH-1:0];
         end
         quo_in   = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH+1]};
         count_in = count_ff - LAST;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags take reset; the operand registers are loaded at start.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      count_ff <= count_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/mfa_gcd.sv
// Binary greatest common divisor unit, one shift or subtract per cycle.
// Depends on mfa_pkg for the phase encoding; gcd(0, d) gives d.
module mfa_gcd #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] operand_a,
   input  logic [DATA_WIDTH-1:0] operand_b,
   output logic [DATA_WIDTH-1:0] result,
   output logic                  done
);

   localparam int KW = $clog2(DATA_WIDTH);
   localparam logic [KW-1:0] K_ONE = KW'(1);

   mfa_pkg::gcd_phase_type phase_ff, phase_in;
   logic [DATA_WIDTH-1:0]  x_ff, x_in;
   logic [DATA_WIDTH-1:0]  y_ff, y_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [DATA_WIDTH-1:0]  result_ff, result_in;
   logic                   done_ff, done_in;

   always_comb begin
      phase_in  = phase_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      k_in      = k_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      if (start) begin
         x_in     = operand_a;
         y_in     = operand_b;
         k_in     = '0;
         phase_in = mfa_pkg::GCD_TWOS;
      end else begin
         unique case (phase_ff)
            mfa_pkg::GCD_IDLE: begin
            end
            // Strip the common factors of two, counting them.
            mfa_pkg::GCD_TWOS: begin
               priority if (x_ff == '0) begin
                  result_in = y_ff;
                  done_in   = 1'b1;
                  phase_in  = mfa_pkg::GCD_IDLE;
               end else if (y_ff == '0) begin
                  result_in = x_ff;
                  done_in   = 1'b1;
                  phase_in  = mfa_pkg::GCD_IDLE;
               end else if (!x_ff[0] && !y_ff[0]) begin
                  x_in = x_ff >> 1;
                  y_in = y_ff >> 1;
                  k_in = k_ff + K_ONE;
               end else begin
                  phase_in = mfa_pkg::GCD_ODD;
               end
            end
            // Reduce: drop lone factors of two, subtract the smaller odd value.
            mfa_pkg::GCD_ODD: begin
               priority if (!x_ff[0]) begin
                  x_in = x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end else if (x_ff == y_ff) begin
                  result_in = x_ff << k_ff;
                  done_in   = 1'b1;
                  phase_in  = mfa_pkg::GCD_IDLE;
               end else if (x_ff > y_ff) begin
                  x_in = x_ff - y_ff;
               end else begin
                  y_in = y_ff - x_ff;
               end
            end
            default: begin
               phase_in = mfa_pkg::GCD_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mfa_pkg::GCD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      k_ff      <= k_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
   assign done   = done_ff;

endmodule

FILE: rtl/mfa_datapath.sv
// Datapath of the mixed fraction ALU: operand and working registers, one
// shared multiplier, the divider and GCD units and the result register.
// Depends on mfa_pkg, mfa_divider and mfa_gcd; driven by mfa_ctrl.
module mfa_datapath #(
   parameter int DATA_WIDTH = mfa_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mfa_pkg::dp_ctrl_type                  ctrl,
   output mfa_pkg::dp_status_type                status,
   input  logic [mfa_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic [mfa_pkg::CMD_WIDTH-1:0]         req_tuser,
   output logic [mfa_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output logic                                  rsp_tuser
);

   localparam int FW = mfa_pkg::FIELD_WIDTH;
   localparam int EW = mfa_pkg::EXT_WIDTH;
   localparam int W  = DATA_WIDTH;

   // Fit a 16-bit signed field to the internal width (wrap or sign extend).
   function automatic logic [W-1:0] fit_in(input logic signed [FW-1:0] v);
      logic signed [EW-1:0] e;
      e = EW'(v);
      return e[W-1:0];
   endfunction

   // Bring an internal value back to a 16-bit field.
   function automatic logic [FW-1:0] fit_out(input logic signed [W-1:0] v);
      logic signed [EW-1:0] e;
      e = EW'(v);
      return e[FW-1:0];
   endfunction

   function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
      logic signed [W-1:0] n;
      n = -v;
      return v[W-1] ? W'(n) : W'(v);
   endfunction

   mfa_pkg::alu_cmd_type cmd_ff, cmd_in;
   logic signed [W-1:0] aw_ff, aw_in, an_ff, an_in, ad_ff, ad_in;
   logic signed [W-1:0] bw_ff, bw_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [W-1:0] l_ff, l_in, t_ff, t_in;
   logic signed [W-1:0] rw_ff, rw_in, rn_ff, rn_in, rd_ff, rd_in;
   logic                err_ff, err_in;
   logic                q_neg_ff, q_neg_in, r_neg_ff, r_neg_in;
   logic [mfa_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_flag_ff, rsp_flag_in;

   logic [W-1:0]        mul_a, mul_b, mul_p;
   logic                div_start, div_done;
   logic [W-1:0]        div_n, div_d, div_quo, div_rem;
   logic                div_n_neg, div_d_neg;
   logic                gcd_start, gcd_done;
   logic [W-1:0]        gcd_a, gcd_b, gcd_res;
   logic signed [W-1:0] q_val, r_val, neg_p;
   logic                is_mul, is_sub;

   assign is_mul = (cmd_ff == mfa_pkg::CMD_MUL);
   assign is_sub = (cmd_ff == mfa_pkg::CMD_SUB);

   // Shared multiplier; only the low word is ever needed since results wrap.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         mfa_pkg::OP_LCM: begin
            mul_a = mag_of(ad_ff);
            mul_b = t_ff;
         end
         mfa_pkg::OP_MUL_TA: begin
            mul_a = an_ff;
            mul_b = t_ff;
         end
         mfa_pkg::OP_MUL_TB: begin
            mul_a = bn_ff;
            mul_b = t_ff;
         end
         mfa_pkg::OP_MUL_AW: begin
            mul_a = aw_ff;
            mul_b = ad_ff;
         end
         mfa_pkg::OP_MUL_BW: begin
            mul_a = bw_ff;
            mul_b = bd_ff;
         end
         mfa_pkg::OP_MUL_RN: begin
            mul_a = an_ff;
            mul_b = is_mul ? bn_ff : bd_ff;
         end
         mfa_pkg::OP_MUL_RD: begin
            mul_a = ad_ff;
            mul_b = is_mul ? bd_ff : bn_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = W'(mul_a * mul_b);
   assign neg_p = -$signed(mul_p);

   // Divider operand selection as sign and magnitude.
   always_comb begin
      div_start = 1'b1;
      div_n     = '0;
      div_d     = '0;
      div_n_neg = 1'b0;
      div_d_neg = 1'b0;
      unique case (ctrl.op)
         mfa_pkg::OP_DIV_BG: begin
            div_n = mag_of(bd_ff);
            div_d = gcd_res;
         end
         mfa_pkg::OP_DIV_LA: begin
            div_n     = mag_of(l_ff);
            div_d     = mag_of(ad_ff);
            div_n_neg = l_ff[W-1];
            div_d_neg = ad_ff[W-1];
         end
         mfa_pkg::OP_DIV_LB: begin
            div_n     = mag_of(l_ff);
            div_d     = mag_of(bd_ff);
            div_n_neg = l_ff[W-1];
            div_d_neg = bd_ff[W-1];
         end
         mfa_pkg::OP_DIV_NR: begin
            div_n     = mag_of(rn_ff);
            div_d     = mag_of(rd_ff);
            div_n_neg = rn_ff[W-1];
            div_d_neg = rd_ff[W-1];
         end
         mfa_pkg::OP_DIV_NG: begin
            div_n     = mag_of(rn_ff);
            div_d     = gcd_res;
            div_n_neg = rn_ff[W-1];
         end
         mfa_pkg::OP_DIV_DG: begin
            div_n     = mag_of(rd_ff);
            div_d     = gcd_res;
            div_n_neg = rd_ff[W-1];
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // GCD operand selection.
   always_comb begin
      gcd_start = 1'b0;
      gcd_a     = '0;
      gcd_b     = '0;
      unique case (ctrl.op)
         mfa_pkg::OP_GCD_DEN: begin
            gcd_start = 1'b1;
            gcd_a     = mag_of(ad_ff);
            gcd_b     = mag_of(bd_ff);
         end
         mfa_pkg::OP_GCD_RES: begin
            gcd_start = 1'b1;
            gcd_a     = mag_of(rn_ff);
            gcd_b     = mag_of(rd_ff);
         end
         default: begin
         end
      endcase
   end

   // Truncating signed quotient and remainder from the magnitude divider.
   assign q_val = q_neg_ff ? -$signed(div_quo) : $signed(div_quo);
   assign r_val = r_neg_ff ? -$signed(div_rem) : $signed(div_rem);

   // Register updates per micro-operation.
   always_comb begin
      cmd_in      = cmd_ff;
      aw_in       = aw_ff;
      an_in       = an_ff;
      ad_in       = ad_ff;
      bw_in       = bw_ff;
      bn_in       = bn_ff;
      bd_in       = bd_ff;
      l_in        = l_ff;
      t_in        = t_ff;
      rw_in       = rw_ff;
      rn_in       = rn_ff;
      rd_in       = rd_ff;
      err_in      = err_ff;
      q_neg_in    = q_neg_ff;
      r_neg_in    = r_neg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_flag_in = rsp_flag_ff;
      if (div_start) begin
         q_neg_in = div_n_neg ^ div_d_neg;
         r_neg_in = div_n_neg;
      end
      unique case (ctrl.op)
         mfa_pkg::OP_LOAD: begin
            cmd_in = mfa_pkg::alu_cmd_type'(req_tuser);
            aw_in  = fit_in(req_tdata[0*FW +: FW]);
            an_in  = fit_in(req_tdata[1*FW +: FW]);
            ad_in  = fit_in(req_tdata[2*FW +: FW]);
            bw_in  = fit_in(req_tdata[3*FW +: FW]);
            bn_in  = fit_in(req_tdata[4*FW +: FW]);
            bd_in  = fit_in(req_tdata[5*FW +: FW]);
            err_in = 1'b0;
         end
         mfa_pkg::OP_LCM: begin
            l_in = (ad_ff[W-1] ^ bd_ff[W-1]) ? neg_p : $signed(mul_p);
         end
         mfa_pkg::OP_WB_T:   t_in = q_val;
         mfa_pkg::OP_MUL_TA: rn_in = $signed(mul_p);
         mfa_pkg::OP_MUL_TB: t_in = $signed(mul_p);
         mfa_pkg::OP_COMBINE: begin
            rn_in = is_sub ? rn_ff - t_ff : rn_ff + t_ff;
            rw_in = is_sub ? aw_ff - bw_ff : aw_ff + bw_ff;
            rd_in = l_ff;
         end
         mfa_pkg::OP_WB_QR_ADD: begin
            rw_in = rw_ff + q_val;
            rn_in = r_val;
         end
         mfa_pkg::OP_WB_QR_SET: begin
            rw_in = q_val;
            rn_in = r_val;
         end
         mfa_pkg::OP_WB_RN:  rn_in = q_val;
         mfa_pkg::OP_WB_RD:  rd_in = q_val;
         mfa_pkg::OP_MUL_AW: t_in = $signed(mul_p);
         mfa_pkg::OP_ADD_A:  an_in = an_ff + t_ff;
         mfa_pkg::OP_MUL_BW: t_in = $signed(mul_p);
         mfa_pkg::OP_ADD_B:  bn_in = bn_ff + t_ff;
         mfa_pkg::OP_MUL_RN: rn_in = $signed(mul_p);
         mfa_pkg::OP_MUL_RD: rd_in = $signed(mul_p);
         mfa_pkg::OP_ERR: begin
            rw_in  = '0;
            rn_in  = '0;
            rd_in  = '0;
            err_in = 1'b1;
         end
         mfa_pkg::OP_EMIT: begin
            rsp_data_in = {fit_out(rd_ff), fit_out(rn_ff), fit_out(rw_ff)};
            rsp_flag_in = err_ff;
         end
         default: begin
         end
      endcase
   end

   // Payload registers only; sequencing lives in the controller.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      aw_ff       <= aw_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      bw_ff       <= bw_in;
      bn_ff       <= bn_in;
      bd_ff       <= bd_in;
      l_ff        <= l_in;
      t_ff        <= t_in;
      rw_ff       <= rw_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      err_ff      <= err_in;
      q_neg_ff    <= q_neg_in;
      r_neg_ff    <= r_neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   mfa_divider #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   mfa_gcd #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start),
      .operand_a (gcd_a),
      .operand_b (gcd_b),
      .result    (gcd_res),
      .done      (gcd_done)
   );

   // Status back to the controller.
   always_comb begin
      status.den_zero  = (ad_ff == '0) || (bd_ff == '0);
      status.is_muldiv = (cmd_ff == mfa_pkg::CMD_MUL) || (cmd_ff == mfa_pkg::CMD_DIV);
      status.rd_zero   = (rd_ff == '0);
      status.rn_ge_rd  = (rn_ff >= rd_ff);
      status.div_done  = div_done;
      status.gcd_done  = gcd_done;
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_flag_ff;

endmodule

FILE: rtl/mfa_ctrl.sv
// Controller of the mixed fraction ALU: sequences the datapath micro-operations
// and runs the request and result handshakes. Depends on mfa_pkg.
module mfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  mfa_pkg::dp_status_type status,
   output mfa_pkg::dp_ctrl_type   ctrl
);

   mfa_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_free;

   // The result register can be refilled once its content is taken.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      ctrl.op      = mfa_pkg::OP_IDLE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         mfa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.op  = mfa_pkg::OP_LOAD;
               state_in = mfa_pkg::ST_CHECK;
            end
         end
         mfa_pkg::ST_CHECK: begin
            priority if (status.den_zero) begin
               state_in = mfa_pkg::ST_ERR;
            end else if (status.is_muldiv) begin
               ctrl.op  = mfa_pkg::OP_MUL_AW;
               state_in = mfa_pkg::ST_ADD_A;
            end else begin
               ctrl.op  = mfa_pkg::OP_GCD_DEN;
               state_in = mfa_pkg::ST_W_GCD_L;
            end
         end
         // Add and subtract: least common multiple and scaled numerators.
         mfa_pkg::ST_W_GCD_L: begin
            if (status.gcd_done) begin
               ctrl.op  = mfa_pkg::OP_DIV_BG;
               state_in = mfa_pkg::ST_W_BG;
            end
         end
         mfa_pkg::ST_W_BG: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_T;
               state_in = mfa_pkg::ST_LCM;
            end
         end
         mfa_pkg::ST_LCM: begin
            ctrl.op  = mfa_pkg::OP_LCM;
            state_in = mfa_pkg::ST_START_LA;
         end
         mfa_pkg::ST_START_LA: begin
            ctrl.op  = mfa_pkg::OP_DIV_LA;
            state_in = mfa_pkg::ST_W_LA;
         end
         mfa_pkg::ST_W_LA: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_T;
               state_in = mfa_pkg::ST_MUL_TA;
            end
         end
         mfa_pkg::ST_MUL_TA: begin
            ctrl.op  = mfa_pkg::OP_MUL_TA;
            state_in = mfa_pkg::ST_START_LB;
         end
         mfa_pkg::ST_START_LB: begin
            ctrl.op  = mfa_pkg::OP_DIV_LB;
            state_in = mfa_pkg::ST_W_LB;
         end
         mfa_pkg::ST_W_LB: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_T;
               state_in = mfa_pkg::ST_MUL_TB;
            end
         end
         mfa_pkg::ST_MUL_TB: begin
            ctrl.op  = mfa_pkg::OP_MUL_TB;
            state_in = mfa_pkg::ST_COMBINE;
         end
         mfa_pkg::ST_COMBINE: begin
            ctrl.op  = mfa_pkg::OP_COMBINE;
            state_in = mfa_pkg::ST_CARRY;
         end
         // Carry into the whole part only when the numerator reaches the denominator.
         mfa_pkg::ST_CARRY: begin
            if (status.rn_ge_rd) begin
               ctrl.op  = mfa_pkg::OP_DIV_NR;
               state_in = mfa_pkg::ST_W_CARRY;
            end else begin
               state_in = mfa_pkg::ST_EMIT;
            end
         end
         mfa_pkg::ST_W_CARRY: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_QR_ADD;
               state_in = mfa_pkg::ST_EMIT;
            end
         end
         // Multiply and divide: improper fractions, product, split and reduce.
         mfa_pkg::ST_ADD_A: begin
            ctrl.op  = mfa_pkg::OP_ADD_A;
            state_in = mfa_pkg::ST_MUL_BW;
         end
         mfa_pkg::ST_MUL_BW: begin
            ctrl.op  = mfa_pkg::OP_MUL_BW;
            state_in = mfa_pkg::ST_ADD_B;
         end
         mfa_pkg::ST_ADD_B: begin
            ctrl.op  = mfa_pkg::OP_ADD_B;
            state_in = mfa_pkg::ST_MUL_RN;
         end
         mfa_pkg::ST_MUL_RN: begin
            ctrl.op  = mfa_pkg::OP_MUL_RN;
            state_in = mfa_pkg::ST_MUL_RD;
         end
         mfa_pkg::ST_MUL_RD: begin
            ctrl.op  = mfa_pkg::OP_MUL_RD;
            state_in = mfa_pkg::ST_TEST_RD;
         end
         mfa_pkg::ST_TEST_RD: begin
            if (status.rd_zero) begin
               state_in = mfa_pkg::ST_ERR;
            end else begin
               ctrl.op  = mfa_pkg::OP_DIV_NR;
               state_in = mfa_pkg::ST_W_QR;
            end
         end
         mfa_pkg::ST_W_QR: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_QR_SET;
               state_in = mfa_pkg::ST_GCD_R;
            end
         end
         mfa_pkg::ST_GCD_R: begin
            ctrl.op  = mfa_pkg::OP_GCD_RES;
            state_in = mfa_pkg::ST_W_GCD_R;
         end
         mfa_pkg::ST_W_GCD_R: begin
            if (status.gcd_done) begin
               ctrl.op  = mfa_pkg::OP_DIV_NG;
               state_in = mfa_pkg::ST_W_NG;
            end
         end
         mfa_pkg::ST_W_NG: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_RN;
               state_in = mfa_pkg::ST_START_DG;
            end
         end
         mfa_pkg::ST_START_DG: begin
            ctrl.op  = mfa_pkg::OP_DIV_DG;
            state_in = mfa_pkg::ST_W_DG;
         end
         mfa_pkg::ST_W_DG: begin
            if (status.div_done) begin
               ctrl.op  = mfa_pkg::OP_WB_RD;
               state_in = mfa_pkg::ST_EMIT;
            end
         end
         mfa_pkg::ST_ERR: begin
            ctrl.op  = mfa_pkg::OP_ERR;
            state_in = mfa_pkg::ST_EMIT;
         end
         // Hand the result to the output register once it is free.
         mfa_pkg::ST_EMIT: begin
            if (rsp_free) begin
               ctrl.op      = mfa_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = mfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: dv/mixed_fraction_alu_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for mixed_fraction_alu_unit: directed and random requests on all
// four operations, with idling and stalls on both stream sides. Depends on mfa_pkg and the RTL.
module mixed_fraction_alu_unit_test;

   localparam int QUIET_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 250;
   localparam int PHASE_ITEMS  = 300;
   localparam int LONG_HOLD    = 600;
   localparam int REPORT_LIMIT = 10;

   // One request: operation plus two mixed numbers.
   typedef struct packed {
      mfa_pkg::alu_cmd_type op;
      logic signed [15:0]   a_whole;
      logic signed [15:0]   a_num;
      logic signed [15:0]   a_den;
      logic signed [15:0]   b_whole;
      logic signed [15:0]   b_num;
      logic signed [15:0]   b_den;
   } mixed_request_type;

   // One result: mixed number plus error flag.
   typedef struct packed {
      logic signed [15:0] r_whole;
      logic signed [15:0] r_num;
      logic signed [15:0] r_den;
      logic               status;
   } mixed_result_type;

   // Value mixes for the random requests.
   typedef enum int {
      MIX_SMALL,
      MIX_WIDE,
      MIX_EDGE
   } value_mix_type;

   // Predicts the result of each accepted request and checks results in order.
   class fraction_scoreboard;
      mixed_result_type pending_results[$];
      int               mismatch_count;

      function longint wrap16(longint x);
         shortint s;
         s = x[15:0];
         return longint'(s);
      endfunction

      // Euclid on magnitudes; a zero first argument gives the magnitude of the second.
      function longint gcd_of_magnitudes(longint a, longint b);
         longint x, y, t;
         x = (a < 0) ? -a : a;
         y = (b < 0) ? -b : b;
         while (x != 0) begin
            t = y % x;
            y = x;
            x = t;
         end
         return y;
      endfunction

      function mixed_result_type compute_mixed(mixed_request_type r);
         longint           aw, an, ad, bw, bn, bd, rw, rn, rd, l, ta, tb, g;
         logic             err;
         mixed_result_type res;
         aw = r.a_whole;
         an = r.a_num;
         ad = r.a_den;
         bw = r.b_whole;
         bn = r.b_num;
         bd = r.b_den;
         rw = 0;
         rn = 0;
         rd = 0;
         err = 1'b0;
         if (ad == 0 || bd == 0) begin
            err = 1'b1;
         end else if (r.op == mfa_pkg::CMD_ADD || r.op == mfa_pkg::CMD_SUB) begin
            // Common denominator is the signed lcm; carry only when the numerator reaches it.
            g = gcd_of_magnitudes(ad, bd);
            l = wrap16((ad * bd) / g);
            ta = wrap16(an * wrap16(l / ad));
            tb = wrap16(bn * wrap16(l / bd));
            if (r.op == mfa_pkg::CMD_ADD) begin
               rw = wrap16(aw + bw);
               rn = wrap16(ta + tb);
            end else begin
               rw = wrap16(aw - bw);
               rn = wrap16(ta - tb);
            end
            rd = l;
            if (rn >= rd) begin
               rw = wrap16(rw + wrap16(rn / rd));
               rn = wrap16(rn % rd);
            end
         end else begin
            // Improper fractions, then product or cross product, split and reduce.
            if (aw != 0) an = wrap16(an + wrap16(aw * ad));
            if (bw != 0) bn = wrap16(bn + wrap16(bw * bd));
            if (r.op == mfa_pkg::CMD_MUL) begin
               rn = wrap16(an * bn);
               rd = wrap16(ad * bd);
            end else begin
               rn = wrap16(an * bd);
               rd = wrap16(ad * bn);
            end
            if (rd == 0) begin
               err = 1'b1;
            end else begin
               rw = wrap16(rn / rd);
               rn = wrap16(rn % rd);
               g = gcd_of_magnitudes(rn, rd);
               rn = wrap16(rn / g);
               rd = wrap16(rd / g);
            end
         end
         if (err) begin
            rw = 0;
            rn = 0;
            rd = 0;
         end
         res.r_whole = rw[15:0];
         res.r_num = rn[15:0];
         res.r_den = rd[15:0];
         res.status = err;
         return res;
      endfunction

      function void note_request(mixed_request_type r);
         pending_results.push_back(compute_mixed(r));
      endfunction

      function void check_result(mixed_result_type got);
         mixed_result_type want;
         if (pending_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("Mismatch: result %0d %0d/%0d status %0d with no request pending",
                        got.r_whole, got.r_num, got.r_den, got.status);
            mismatch_count++;
            return;
         end
         want = pending_results.pop_front();
         if (got.r_whole !== want.r_whole || got.r_num !== want.r_num ||
             got.r_den !== want.r_den || got.status !== want.status) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("Mismatch: expected %0d %0d/%0d status %0d, got %0d %0d/%0d status %0d",
                        want.r_whole, want.r_num, want.r_den, want.status,
                        got.r_whole, got.r_num, got.r_den, got.status);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [mfa_pkg::REQ_DATA_WIDTH-1:0] req_tdata;
   logic [mfa_pkg::CMD_WIDTH-1:0]      req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [mfa_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               rsp_tuser;

   fraction_scoreboard board = new();
   int sender_idle_pct = 0;
   int sink_stall_pct = 0;
   int sink_hold_cycles = 0;
   int quiet_cycles = 0;

   mixed_fraction_alu_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one request after a random gap and waits until it is accepted.
   task automatic offer_request(input mixed_request_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.b_den, r.b_num, r.b_whole, r.a_den, r.a_num, r.a_whole};
      req_tuser <= r.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(r);
   endtask

   function automatic mixed_request_type make_request(mfa_pkg::alu_cmd_type op,
                                                      int aw, int an, int ad,
                                                      int bw, int bn, int bd);
      mixed_request_type r;
      r.op = op;
      r.a_whole = aw[15:0];
      r.a_num = an[15:0];
      r.a_den = ad[15:0];
      r.b_whole = bw[15:0];
      r.b_num = bn[15:0];
      r.b_den = bd[15:0];
      return r;
   endfunction

   // Draws one field; denominators of the small mix are mostly positive and nonzero.
   function automatic logic [15:0] pick_value(value_mix_type mix, bit is_den);
      logic [31:0] v;
      int          edges[9];
      edges = '{-32768, -32767, -1, 0, 1, 2, 255, 256, 32767};
      v = $urandom();
      case (mix)
         MIX_SMALL: begin
            if (is_den) begin
               v = $urandom_range(24, 1);
               if ($urandom_range(7) == 0) v = -v;
            end else if ($urandom_range(2) == 0) begin
               v = 0;
            end else begin
               v = int'($urandom_range(42)) - 12;
            end
         end
         MIX_EDGE: v = edges[$urandom_range(8)];
         default: ;
      endcase
      return v[15:0];
   endfunction

   function automatic mixed_request_type random_request();
      mixed_request_type r;
      value_mix_type     mix;
      int unsigned       roll;
      roll = $urandom_range(8);
      mix = (roll < 6) ? MIX_SMALL : (roll < 8) ? MIX_WIDE : MIX_EDGE;
      r.op = mfa_pkg::alu_cmd_type'($urandom_range(3));
      r.a_whole = pick_value(mix, 1'b0);
      r.a_num = pick_value(mix, 1'b0);
      r.a_den = pick_value(mix, 1'b1);
      r.b_whole = pick_value(mix, 1'b0);
      r.b_num = pick_value(mix, 1'b0);
      r.b_den = pick_value(mix, 1'b1);
      // An occasional zero denominator exercises the error path.
      if ($urandom_range(24) == 0) begin
         if ($urandom_range(1) == 0) r.a_den = '0;
         else r.b_den = '0;
      end
      return r;
   endfunction

   // Result side: checks each accepted result and chooses the next ready value.
   initial begin : result_sink
      int               hold_left;
      mixed_result_type got;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.r_whole = rsp_tdata[15:0];
            got.r_num = rsp_tdata[31:16];
            got.r_den = rsp_tdata[47:32];
            got.status = rsp_tuser;
            board.check_result(got);
         end
         if (sink_hold_cycles > 0) begin
            hold_left = sink_hold_cycles;
            sink_hold_cycles = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Watchdog on cycles with no request and no result accepted.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed requests, then four phases of random requests.
   initial begin : stimulus
      mixed_request_type directed[$];
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= mfa_pkg::CMD_ADD;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_request(mfa_pkg::CMD_ADD, 1, 1, 2, 2, 1, 3));
      directed.push_back(make_request(mfa_pkg::CMD_ADD, 0, 3, 4, 0, 3, 4));
      directed.push_back(make_request(mfa_pkg::CMD_SUB, 5, 1, 3, 2, 1, 2));
      directed.push_back(make_request(mfa_pkg::CMD_SUB, 0, 1, 4, 0, 3, 4));
      directed.push_back(make_request(mfa_pkg::CMD_MUL, 1, 1, 2, 2, 2, 3));
      directed.push_back(make_request(mfa_pkg::CMD_DIV, 3, 1, 4, 1, 1, 2));
      // Zero numerator leaves a gcd of zero and the denominator.
      directed.push_back(make_request(mfa_pkg::CMD_MUL, 0, 0, 7, 3, 1, 5));
      // A negative denominator feeds the signed lcm, then a divide with negative parts.
      directed.push_back(make_request(mfa_pkg::CMD_ADD, 0, 1, -3, 0, 1, 6));
      directed.push_back(make_request(mfa_pkg::CMD_DIV, -2, 1, 3, 0, -5, 7));
      // Zero input denominators on every operation.
      directed.push_back(make_request(mfa_pkg::CMD_ADD, 1, 1, 0, 1, 1, 2));
      directed.push_back(make_request(mfa_pkg::CMD_SUB, 1, 1, 2, 1, 1, 0));
      directed.push_back(make_request(mfa_pkg::CMD_MUL, 2, 3, 0, 1, 1, 2));
      directed.push_back(make_request(mfa_pkg::CMD_DIV, 2, 3, 4, 0, 1, 0));
      // Divide by a zero operand, and a denominator product that wraps to zero.
      directed.push_back(make_request(mfa_pkg::CMD_DIV, 0, 1, 5, 0, 0, 9));
      directed.push_back(make_request(mfa_pkg::CMD_MUL, 0, 1, 256, 0, 1, 256));
      // Field extremes and wrapping quotients.
      directed.push_back(make_request(mfa_pkg::CMD_ADD, 32767, 32767, 32767,
                                      32767, 32767, 32767));
      directed.push_back(make_request(mfa_pkg::CMD_SUB, -32768, -32768, -32768,
                                      -32768, -32768, -32768));
      directed.push_back(make_request(mfa_pkg::CMD_MUL, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(mfa_pkg::CMD_DIV, 0, -32768, 1, 0, -1, 1));
      directed.push_back(make_request(mfa_pkg::CMD_MUL, 32767, 32767, 32767,
                                      -32768, -32768, -32768));
      directed.push_back(make_request(mfa_pkg::CMD_DIV, -1, 32767, -32768,
                                      32767, -1, 32767));
      directed.push_back(make_request(mfa_pkg::CMD_ADD, 100, 7, 3, -50, 5, 3));
      foreach (directed[i]) offer_request(directed[i]);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; sink_stall_pct = 0;  end
            2: begin
               sender_idle_pct = 0;
               sink_stall_pct = 57;
               // Long receiver hold-off while requests keep coming, to back up the input.
               sink_hold_cycles = LONG_HOLD;
            end
            default: begin sender_idle_pct = 37; sink_stall_pct = 37; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) offer_request(random_request());
      end
      req_tvalid <= 1'b0;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
